// ----- hdl/gpad_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants shared by the gamepad poll decoder modules.
package gpad_pkg;

    // One input tick: poll request flag and sampled controller data pin.
    typedef struct packed {
        logic req_type;
        logic data_in;
    } t_in_item;

    // One result per tick: pin levels after the tick and the decoded poll data.
    typedef struct packed {
        logic       select_n;
        logic       clock_out;
        logic       command_out;
        logic       done_res;
        logic [7:0] mode_id;
        logic [15:0] buttons_raw;
        logic [4:0] key_code;
        logic [7:0] right_x;
        logic [7:0] right_y;
        logic [7:0] left_x;
        logic [7:0] left_y;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_GAP  = 2'd2
    } t_phase;

    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_BYTE_GAP    = 2'd1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
    localparam logic [15:0] BYTE_GAP_RESET    = 16'd800;

    localparam logic [7:0] CMD_FIRST  = 8'h01;
    localparam logic [7:0] CMD_SECOND = 8'h42;

    localparam logic [3:0] BYTE_ID     = 4'd1;
    localparam logic [3:0] BYTE_BTN_LO = 4'd3;
    localparam logic [3:0] BYTE_BTN_HI = 4'd4;
    localparam logic [3:0] BYTE_STICK0 = 4'd5;
    localparam logic [3:0] BYTE_LAST   = 4'd8;

    localparam logic [15:0] COMBO_L1_TRI = 16'h1400;
    localparam logic [15:0] COMBO_L1_CRS = 16'h4400;
    localparam logic [15:0] COMBO_L1_SQR = 16'h8400;
    localparam logic [15:0] COMBO_L1_CIR = 16'h2400;

    localparam logic [4:0] KEY_NONE     = 5'd0;
    localparam logic [4:0] KEY_L1_TRI   = 5'd17;
    localparam logic [4:0] KEY_L1_CRS   = 5'd18;
    localparam logic [4:0] KEY_L1_SQR   = 5'd19;
    localparam logic [4:0] KEY_L1_CIR   = 5'd20;

endpackage

// ----- hdl/gpad_keydec.sv -----
`timescale 1ns / 1ps
// Key decoder: turns the active-low button word into a key code.
module gpad_keydec (
    input  logic [15:0] i_buttons_raw,
    output logic [4:0]  o_key_code
);
    import gpad_pkg::*;

    logic [15:0] pressed;

    always_comb begin
        pressed    = ~i_buttons_raw;
        o_key_code = KEY_NONE;
        for (int i = 0; i < 16; i++) begin
            if (pressed == (16'h0001 << i)) begin
                o_key_code = 5'(i + 1);
            end
        end
        if (pressed == COMBO_L1_TRI) begin
            o_key_code = KEY_L1_TRI;
        end else if (pressed == COMBO_L1_CRS) begin
            o_key_code = KEY_L1_CRS;
        end else if (pressed == COMBO_L1_SQR) begin
            o_key_code = KEY_L1_SQR;
        end else if (pressed == COMBO_L1_CIR) begin
            o_key_code = KEY_L1_CIR;
        end
    end

endmodule

// ----- hdl/gpad_seq.sv -----
`timescale 1ns / 1ps
// Poll sequencer: bit timing, byte shifting, response stores and result forming.
module gpad_seq #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  gpad_pkg::t_in_item   i_item,
    input  logic [15:0]          i_half_period,
    input  logic [15:0]          i_byte_gap,
    output gpad_pkg::t_out_item  o_result
);
    import gpad_pkg::*;

    localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    logic                   r_busy, n_busy;
    t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_timer, n_timer;
    logic [2:0]             r_bit, n_bit;
    logic [3:0]             r_byte, n_byte;
    logic [7:0]             r_shift, n_shift;
    logic                   r_cmd, n_cmd;
    logic [7:0]             r_id, n_id;
    logic [15:0]            r_buttons, n_buttons;
    logic [7:0]             r_stick [4];
    logic [7:0]             n_stick [4];
    logic [4:0]             r_code, n_code;

    logic [TIMER_WIDTH-1:0] tick_inc;
    logic [15:0]            limit;
    logic                   expired;
    logic                   done;
    logic                   finish_byte;
    logic [7:0]             shift_full;
    logic [4:0]             dec_code;

    gpad_keydec u_keydec (
        .i_buttons_raw (r_buttons),
        .o_key_code    (dec_code)
    );

    always_comb begin
        tick_inc   = (r_timer == TMAX) ? r_timer : r_timer + 1'b1;
        limit      = (r_phase == PH_HIGH || r_phase == PH_LOW) ? i_half_period : i_byte_gap;
        expired    = (CW'(tick_inc) >= CW'(limit)) || (tick_inc == TMAX);
        shift_full = r_shift | (8'(i_item.data_in) << r_bit);
    end

    always_comb begin
        n_busy      = r_busy;
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_shift     = r_shift;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_buttons   = r_buttons;
        n_stick     = r_stick;
        n_code      = r_code;
        done        = 1'b0;
        finish_byte = 1'b0;

        if (!r_busy) begin
            if (i_item.req_type) begin
                n_busy  = 1'b1;
                n_phase = PH_HIGH;
                n_timer = '0;
                n_bit   = '0;
                n_byte  = '0;
                n_shift = '0;
                n_cmd   = CMD_FIRST[0];
            end
        end else begin
            case (r_phase)
                PH_HIGH: begin
                    n_timer = tick_inc;
                    if (expired) begin
                        n_phase = PH_LOW;
                        n_timer = '0;
                    end
                end
                PH_LOW: begin
                    n_timer = tick_inc;
                    if (expired) begin
                        n_shift = shift_full;
                        n_timer = '0;
                        n_phase = PH_HIGH;
                        if (r_bit != 3'd7) begin
                            n_bit = r_bit + 3'd1;
                            if (r_byte == 4'd0) begin
                                n_cmd = CMD_FIRST[n_bit];
                            end else if (r_byte == BYTE_ID) begin
                                n_cmd = CMD_SECOND[n_bit];
                            end else begin
                                n_cmd = 1'b0;
                            end
                        end else begin
                            // store the completed response byte
                            if (r_byte == BYTE_ID) begin
                                n_id = shift_full;
                            end else if (r_byte == BYTE_BTN_LO) begin
                                n_buttons[7:0] = shift_full;
                            end else if (r_byte == BYTE_BTN_HI) begin
                                n_buttons[15:8] = shift_full;
                            end else if (r_byte >= BYTE_STICK0 && r_byte <= BYTE_LAST) begin
                                n_stick[2'(r_byte - BYTE_STICK0)] = shift_full;
                            end
                            if (r_byte < 4'd2 || i_byte_gap == 16'd0) begin
                                finish_byte = 1'b1;
                            end else begin
                                n_phase = PH_GAP;
                            end
                        end
                    end
                end
                default: begin
                    n_timer = tick_inc;
                    if (expired) begin
                        finish_byte = 1'b1;
                    end
                end
            endcase
        end

        if (finish_byte) begin
            n_timer = '0;
            n_bit   = '0;
            n_shift = '0;
            n_phase = PH_HIGH;
            if (r_byte >= BYTE_LAST) begin
                n_busy = 1'b0;
                n_code = dec_code;
                done   = 1'b1;
            end else begin
                n_byte = r_byte + 4'd1;
                n_cmd  = 1'b0;
            end
        end
    end

    always_comb begin
        o_result.select_n    = ~n_busy;
        o_result.clock_out   = ~(n_busy && n_phase == PH_LOW);
        o_result.command_out = n_cmd;
        o_result.done_res    = done;
        o_result.mode_id     = n_id;
        o_result.buttons_raw = n_buttons;
        o_result.key_code    = n_code;
        o_result.right_x     = n_stick[0];
        o_result.right_y     = n_stick[1];
        o_result.left_x      = n_stick[2];
        o_result.left_y      = n_stick[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_phase   <= PH_HIGH;
            r_timer   <= '0;
            r_bit     <= '0;
            r_byte    <= '0;
            r_shift   <= '0;
            r_cmd     <= 1'b0;
            r_id      <= '0;
            r_buttons <= 16'hFFFF;
            r_stick   <= '{default: 8'h00};
            r_code    <= KEY_NONE;
        end else if (i_step) begin
            r_busy    <= n_busy;
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_bit     <= n_bit;
            r_byte    <= n_byte;
            r_shift   <= n_shift;
            r_cmd     <= n_cmd;
            r_id      <= n_id;
            r_buttons <= n_buttons;
            r_stick   <= n_stick;
            r_code    <= n_code;
        end
    end

endmodule

// ----- hdl/gpad_obuf.sv -----
`timescale 1ns / 1ps
// Two-entry output buffer that decouples result delivery from tick acceptance.
module gpad_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  gpad_pkg::t_out_item  i_data,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output gpad_pkg::t_out_item  o_data
);
    import gpad_pkg::*;

    logic [1:0] r_count;
    t_out_item  r_head;
    t_out_item  r_tail;
    logic       pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_head;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

    // payload moves: head takes the tail or the new transfer, tail takes the new one
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_count == 2'd2) begin
                r_head <= r_tail;
                if (i_push) begin
                    r_tail <= i_data;
                end
            end else if (i_push) begin
                r_head <= i_data;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_head <= i_data;
            end else begin
                r_tail <= i_data;
            end
        end
    end

endmodule

// ----- hdl/gamepad_serial_poll_decoder_top.sv -----
`timescale 1ns / 1ps
// Top level of the gamepad serial poll decoder.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_data): one transfer is one
//    tick of the pin sequencer. req_type starts a poll when idle; data_in is
//    the sampled controller data pin. Requests during a poll are dropped.
//  - Output channel (o_out_valid / i_out_ready / o_out_data): exactly one
//    result per input transfer, in order: chip select, serial clock and
//    command levels after the tick, a done strobe, and the stored poll data.
//  - Config port (i_cfg_we / i_cfg_idx / i_cfg_wdata): index 0 sets the half
//    bit period in ticks, index 1 the gap after each data byte. Other indexes
//    are dropped. Write only while idle.
//  - Each result is registered in the output buffer before it is offered.
//    Throughput: one tick per cycle, limited only by the output handshake.
//  - Stall: a two-entry output buffer keeps accepting while one result waits;
//    with both entries held, o_in_ready drops and the sequencer holds.
//  - Reset (synchronous, active low): sequencer idle, buttons all released,
//    other stores cleared, registers back to 50 and 800 ticks.
module gamepad_serial_poll_decoder_top #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gpad_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gpad_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_wdata
);
    import gpad_pkg::*;

    logic [15:0] r_half_period;
    logic [15:0] r_byte_gap;
    logic        in_xfer;
    t_out_item   seq_result;

    assign in_xfer = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
            r_byte_gap    <= BYTE_GAP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_HALF_PERIOD) begin
                r_half_period <= i_cfg_wdata;
            end else if (i_cfg_idx == CFG_BYTE_GAP) begin
                r_byte_gap <= i_cfg_wdata;
            end
        end
    end

    // advance the sequencer by one tick per accepted transfer
    gpad_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_xfer),
        .i_item        (i_in_data),
        .i_half_period (r_half_period),
        .i_byte_gap    (r_byte_gap),
        .o_result      (seq_result)
    );

    // hold results until the receiver takes them
    gpad_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_data  (seq_result),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ----- sim/tb_gamepad_serial_poll_decoder_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: random and directed polls through the gamepad poll decoder.
module tb_gamepad_serial_poll_decoder_top;
    import gpad_pkg::*;

    localparam int      TIMER_W          = 16;
    localparam int      RANDOM_TICKS     = 600;
    localparam int      PHASE_TICKS      = 200;
    localparam int      QUIET_TAIL       = 200;
    localparam int      LONG_HOLD_CYCLES = 400;
    localparam int      LONG_HOLD_AFTER  = 600;
    localparam int      SETTLE_CYCLES    = 8;
    localparam int      MAX_REPORTS      = 40;
    localparam int      GAP_PROBE_TICKS  = 40;
    localparam longint  LIMIT_NS         = 10_000_000;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [3:0][15:0] L1_COMBOS = {COMBO_L1_CIR, COMBO_L1_SQR,
                                              COMBO_L1_CRS, COMBO_L1_TRI};

    typedef struct packed {
        logic               busy;
        t_phase             phase;
        logic [TIMER_W-1:0] timer;
        logic [2:0]         bit_idx;
        logic [3:0]         byte_idx;
        logic [7:0]         rx_byte;
        logic               cmd;
        logic [7:0]         id;
        logic [15:0]        buttons;
        logic [3:0][7:0]    sticks;
        logic [4:0]         code;
    } t_poll_state;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = '0;
    logic [15:0] i_cfg_wdata = '0;

    // Register copies used by the poll predictor.
    logic [15:0] half_ticks = HALF_PERIOD_RESET;
    logic [15:0] gap_ticks  = BYTE_GAP_RESET;

    t_in_item    ticks_to_send[$];
    t_out_item   poll_results_due[$];
    t_poll_state gen_state;
    t_poll_state chk_state;

    int          n_queued  = 0;
    int          n_sent    = 0;
    int          n_checked = 0;
    int          n_errors  = 0;
    int          polls_done = 0;
    logic [31:0] codes_seen = '0;
    logic        in_taken  = 1'b0;
    logic        quiet     = 1'b0;
    int          send_gap  = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    logic        long_hold_done = 1'b0;

    gamepad_serial_poll_decoder_top #(
        .TIMER_WIDTH(TIMER_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Poll predictor
    // ---------------------------------------------------------------
    function automatic t_poll_state idle_state();
        t_poll_state s;
        s         = '0;
        s.phase   = PH_HIGH;
        s.buttons = '1;
        return s;
    endfunction

    function automatic logic [4:0] decode_pressed(logic [15:0] raw);
        logic [15:0] pressed;
        logic [4:0]  code;
        pressed = ~raw;
        code    = KEY_NONE;
        for (int i = 0; i < 16; i++) begin
            if (pressed == (16'd1 << i)) code = 5'(i + 1);
        end
        case (pressed)
            COMBO_L1_TRI: code = KEY_L1_TRI;
            COMBO_L1_CRS: code = KEY_L1_CRS;
            COMBO_L1_SQR: code = KEY_L1_SQR;
            COMBO_L1_CIR: code = KEY_L1_CIR;
            default: ;
        endcase
        return code;
    endfunction

    // Count one tick of the current phase; the timer saturates and a full
    // timer ends the phase as well.
    function automatic logic tick_over(inout t_poll_state s, input logic [15:0] limit);
        if (s.timer != '1) s.timer = s.timer + 1'b1;
        return (s.timer >= limit) || (s.timer == '1);
    endfunction

    // Advance past a finished byte and its gap; return 1 when the poll ends.
    function automatic logic next_byte(inout t_poll_state s);
        s.timer   = '0;
        s.bit_idx = '0;
        s.rx_byte = '0;
        s.phase   = PH_HIGH;
        if (s.byte_idx >= BYTE_LAST) begin
            s.busy = 1'b0;
            s.code = decode_pressed(s.buttons);
            return 1'b1;
        end
        s.byte_idx = s.byte_idx + 1'b1;
        s.cmd      = (s.byte_idx == BYTE_ID) ? CMD_SECOND[0] : 1'b0;
        return 1'b0;
    endfunction

    function automatic t_out_item poll_tick(inout t_poll_state s, input t_in_item it);
        t_out_item r;
        logic      done;
        done = 1'b0;
        if (!s.busy) begin
            if (it.req_type) begin
                s.busy     = 1'b1;
                s.phase    = PH_HIGH;
                s.timer    = '0;
                s.bit_idx  = '0;
                s.byte_idx = '0;
                s.rx_byte  = '0;
                s.cmd      = CMD_FIRST[0];
            end
        end else if (s.phase == PH_HIGH) begin
            if (tick_over(s, half_ticks)) begin
                s.phase = PH_LOW;
                s.timer = '0;
            end
        end else if (s.phase == PH_LOW) begin
            if (tick_over(s, half_ticks)) begin
                // Sample the data pin on the rising clock edge.
                s.rx_byte = s.rx_byte | (8'(it.data_in) << s.bit_idx);
                s.timer   = '0;
                s.phase   = PH_HIGH;
                if (s.bit_idx != 3'd7) begin
                    s.bit_idx = s.bit_idx + 1'b1;
                    if (s.byte_idx < BYTE_ID)
                        s.cmd = CMD_FIRST[s.bit_idx];
                    else if (s.byte_idx == BYTE_ID)
                        s.cmd = CMD_SECOND[s.bit_idx];
                    else
                        s.cmd = 1'b0;
                end else begin
                    case (s.byte_idx)
                        BYTE_ID:     s.id            = s.rx_byte;
                        BYTE_BTN_LO: s.buttons[7:0]  = s.rx_byte;
                        BYTE_BTN_HI: s.buttons[15:8] = s.rx_byte;
                        default: begin
                            if (s.byte_idx >= BYTE_STICK0 && s.byte_idx <= BYTE_LAST)
                                s.sticks[2'(s.byte_idx - BYTE_STICK0)] = s.rx_byte;
                        end
                    endcase
                    // Command bytes have no gap; data bytes skip it when it is zero.
                    if (s.byte_idx <= BYTE_ID || gap_ticks == '0)
                        done = next_byte(s);
                    else
                        s.phase = PH_GAP;
                end
            end
        end else begin
            if (tick_over(s, gap_ticks)) done = next_byte(s);
        end

        r.select_n    = ~s.busy;
        r.clock_out   = ~(s.busy && s.phase == PH_LOW);
        r.command_out = s.cmd;
        r.done_res    = done;
        r.mode_id     = s.id;
        r.buttons_raw = s.buttons;
        r.key_code    = s.code;
        r.right_x     = s.sticks[0];
        r.right_y     = s.sticks[1];
        r.left_x      = s.sticks[2];
        r.left_y      = s.sticks[3];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    task automatic queue_tick(logic req, logic din);
        t_in_item it;
        it.req_type = req;
        it.data_in  = din;
        ticks_to_send.push_back(it);
        void'(poll_tick(gen_state, it));
        n_queued++;
    endtask

    // Noise: plain ticks with stray requests that may start a poll.
    task automatic queue_noise(int n);
        repeat (n) queue_tick(($urandom % 4) == 0, 1'($urandom % 2));
    endtask

    // Run out a poll in progress; requests on these ticks are dropped.
    task automatic settle_poll();
        while (gen_state.busy) queue_tick(1'($urandom % 2), 1'($urandom % 2));
    endtask

    // Build one well-formed poll: the controller answers with the given
    // bytes on each sampling tick; the other ticks carry random pin noise.
    task automatic queue_poll(logic [8:0][7:0] bytes);
        int h;
        settle_poll();
        h = (half_ticks == '0) ? 1 : int'(half_ticks);
        queue_tick(1'b1, 1'($urandom % 2));
        for (int b = 0; b < 9; b++) begin
            for (int k = 0; k < 8; k++) begin
                for (int t = 1; t < 2 * h; t++)
                    queue_tick(($urandom % 8) == 0, 1'($urandom % 2));
                queue_tick(($urandom % 8) == 0, bytes[b][k]);
            end
            if (b > int'(BYTE_ID))
                repeat (int'(gap_ticks)) queue_tick(($urandom % 8) == 0, 1'($urandom % 2));
        end
    endtask

    function automatic logic [8:0][7:0] random_poll();
        logic [8:0][7:0] bytes;
        logic [15:0]     btn;
        for (int i = 0; i < 9; i++) bytes[i] = 8'($urandom);
        case ($urandom % 6)
            0: btn = '1;
            1: btn = ~(16'd1 << $urandom_range(0, 15));
            2: btn = ~L1_COMBOS[2'($urandom % 4)];
            3: btn = ~(L1_COMBOS[2'($urandom % 4)] | (16'd1 << $urandom_range(0, 15)));
            4: btn = '0;
            default: btn = 16'($urandom);
        endcase
        bytes[BYTE_BTN_LO] = btn[7:0];
        bytes[BYTE_BTN_HI] = btn[15:8];
        for (int i = int'(BYTE_STICK0); i <= int'(BYTE_LAST); i++) begin
            if ($urandom % 3 == 0) bytes[i] = ($urandom % 2) ? 8'hFF : 8'h00;
        end
        return bytes;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_HALF_PERIOD: half_ticks = val;
            CFG_BYTE_GAP:    gap_ticks  = val;
            default: ;
        endcase
    endtask

    // Hold until every queued tick is transferred and every result checked.
    task automatic wait_idle();
        while (n_sent != n_queued || poll_results_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] mismatch on %s at result %0d: got %0h, want %0h",
                     $time, what, n_checked, got, want);
    endtask

    task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (poll_results_due.size() == 0) begin
            report_mismatch("result with none due", '0, '0);
            return;
        end
        want = poll_results_due.pop_front();
        n_checked++;
        if (got.done_res === 1'b1) begin
            polls_done++;
            codes_seen[got.key_code] = 1'b1;
        end
        check_field("select_n",    16'(got.select_n),    16'(want.select_n));
        check_field("clock_out",   16'(got.clock_out),   16'(want.clock_out));
        check_field("command_out", 16'(got.command_out), 16'(want.command_out));
        check_field("done_res",    16'(got.done_res),    16'(want.done_res));
        check_field("mode_id",     16'(got.mode_id),     16'(want.mode_id));
        check_field("buttons_raw", got.buttons_raw,      want.buttons_raw);
        check_field("key_code",    16'(got.key_code),    16'(want.key_code));
        check_field("right_x",     16'(got.right_x),     16'(want.right_x));
        check_field("right_y",     16'(got.right_y),     16'(want.right_y));
        check_field("left_x",      16'(got.left_x),      16'(want.left_x));
        check_field("left_y",      16'(got.left_y),      16'(want.left_y));
    endtask

    // Sample both channels at the rising edge; predict on each input transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) check_result(o_out_data);
            if (i_in_valid && o_in_ready) begin
                poll_results_due.push_back(poll_tick(chk_state, i_in_data));
                n_sent++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Driver and receiver, both on the falling edge
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (ticks_to_send.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                // Insert an idle burst; this cycle is its first.
                send_gap = $urandom_range(0, 16);
                i_in_valid <= 1'b0;
            end else begin
                i_in_data  <= ticks_to_send.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && n_checked >= LONG_HOLD_AFTER) begin
            // Hold off long enough for the output buffer to fill and the
            // input to stall while the sender keeps offering ticks.
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        logic [8:0][7:0] bytes;
        logic [15:0]     btn;
        int              n_mark;
        int              phase_start;

        gen_state = idle_state();
        chk_state = idle_state();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing: plain ticks, then the first two bits of a poll at
        // 50 ticks per clock level.
        repeat (5) queue_tick(1'b0, 1'($urandom % 2));
        queue_tick(1'b1, 1'($urandom % 2));
        repeat (4 * int'(HALF_PERIOD_RESET)) queue_tick(1'($urandom % 2), 1'($urandom % 2));
        wait_idle();

        // Shorten the bit time and run into the first gap at its reset length.
        write_reg(CFG_HALF_PERIOD, 16'd1);
        while (gen_state.busy && gen_state.phase != PH_GAP)
            queue_tick(1'($urandom % 2), 1'($urandom % 2));
        repeat (GAP_PROBE_TICKS) queue_tick(1'($urandom % 2), 1'($urandom % 2));
        wait_idle();

        // Fastest timing; spare register indexes must be dropped.
        write_reg(CFG_BYTE_GAP, 16'd0);
        write_reg(CFG_SPARE_2, 16'd7);
        write_reg(CFG_SPARE_3, 16'hFFFF);
        settle_poll();
        // One single button, one L1 combination, none and all pressed.
        for (int i = 0; i < 4; i++) begin
            bytes = random_poll();
            case (i)
                0:       btn = ~(16'd1 << $urandom_range(0, 15));
                1:       btn = ~L1_COMBOS[2'($urandom % 4)];
                2:       btn = '1;
                default: btn = '0;
            endcase
            bytes[BYTE_BTN_LO] = btn[7:0];
            bytes[BYTE_BTN_HI] = btn[15:8];
            for (int j = int'(BYTE_STICK0); j <= int'(BYTE_LAST); j++)
                bytes[j] = ((i + j) % 2) ? 8'hFF : 8'h00;
            queue_poll(bytes);
        end
        wait_idle();

        // Zero half period acts as one tick; a one-tick gap.
        write_reg(CFG_HALF_PERIOD, 16'd0);
        write_reg(CFG_BYTE_GAP, 16'd1);
        queue_poll(random_poll());
        queue_poll(random_poll());
        wait_idle();

        // Largest settings with plain ticks only; a poll here would run far too long.
        write_reg(CFG_HALF_PERIOD, 16'hFFFF);
        write_reg(CFG_BYTE_GAP, 16'hFFFF);
        repeat (20) queue_tick(1'b0, 1'($urandom % 2));
        wait_idle();

        // Random part: mostly well-formed polls with random answers, some noise.
        // Each phase ends with the sender paused until all results are in.
        n_mark = n_queued;
        while (n_queued - n_mark < RANDOM_TICKS) begin
            if (n_queued - n_mark >= RANDOM_TICKS - QUIET_TAIL) quiet = 1'b1;
            write_reg(CFG_HALF_PERIOD,
                      ($urandom % 3 == 0) ? 16'($urandom_range(2, 3))
                                          : 16'($urandom_range(0, 1)));
            case ($urandom % 3)
                0:       write_reg(CFG_BYTE_GAP, 16'd0);
                1:       write_reg(CFG_BYTE_GAP, 16'd1);
                default: write_reg(CFG_BYTE_GAP, 16'($urandom_range(2, 12)));
            endcase
            phase_start = n_queued;
            while (n_queued - phase_start < PHASE_TICKS) begin
                if ($urandom % 4 == 0)
                    queue_noise($urandom_range(1, 40));
                else
                    queue_poll(random_poll());
            end
            settle_poll();
            wait_idle();
        end

        $display("checked %0d results from %0d ticks, %0d polls completed",
                 n_checked, n_queued, polls_done);
        $display("%0d distinct key codes decoded, half periods 0 to 3 and 50, gaps 0 to 12",
                 $countones(codes_seen));
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/gpad_pkg.sv
hdl/gpad_keydec.sv
hdl/gpad_seq.sv
hdl/gpad_obuf.sv
hdl/gamepad_serial_poll_decoder_top.sv
sim/tb_gamepad_serial_poll_decoder_top.sv
